### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/lgs_pkg.sv
package lgs_pkg;

    localparam int DATA_W     = 64;
    localparam int COLS_W     = 7;
    localparam int CNT_W      = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int FILL_W     = 3;

    localparam logic [CNT_W-1:0]  BORN_COUNT = 4'd3;
    localparam logic [CNT_W-1:0]  KEEP_COUNT = 4'd2;
    localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;

    typedef struct packed {
        logic [DATA_W-1:0] row;
        logic              last;
    } out_item_t;

    // up to two results written per accepted row; en1 implies en0
    typedef struct packed {
        logic      en0;
        logic      en1;
        out_item_t item0;
        out_item_t item1;
    } push_t;

endpackage

### rtl/life_generation_step_top.sv
// One generation of Life (born on 3, kept on 2 or 3) over a grid streamed by rows.
// s_axis: one grid row per transaction, top to bottom. tdata bit x is cell x
//   (1 alive); tlast marks the bottom row of the grid.
// m_axis: next-generation rows, tdata bit x is cell x; tlast on the bottom row.
// cfg_we/cfg_wdata: columns in use (1..64); write only while the block is idle.
// Each row gives the new row of the row above it; the first row of a grid gives
// nothing unless it is also the last, and the last row gives one extra result.
// Throughput: one row per cycle while s_axis_tready is high. Both rows are
// computed side by side by two 64-lane cell arrays in the accept cycle and
// registered into a 4-entry output queue; s_axis_tready is high while at
// least two queue entries are free.
// A last row that completes two results adds one to the queue and the first
// row of the next grid drains it, so the queue never holds more than two and
// input runs at one row per cycle while m_axis_tready stays high.
// A stalled m_axis_tready holds the queue head; input stops once the queue
// has fewer than two free entries.
// Reset: no rows held, queue empty, columns in use 64.
`include "assert_macros.svh"

module life_generation_step_top #(
    parameter int ROW_WIDTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lgs_pkg::COLS_W-1:0] cfg_wdata,      // cols_in_use
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [lgs_pkg::DATA_W-1:0] s_axis_tdata,   // row_bits[63:0]
    input  logic                      s_axis_tlast,   // last_row
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [lgs_pkg::DATA_W-1:0] m_axis_tdata,   // next_row[63:0]
    output logic                      m_axis_tlast    // last_out
);
    import lgs_pkg::*;

    logic [COLS_W-1:0]    cols_reg;
    logic [ROW_WIDTH-1:0] above_reg;
    logic [ROW_WIDTH-1:0] above_next;
    logic [ROW_WIDTH-1:0] middle_reg;
    logic [ROW_WIDTH-1:0] middle_next;
    logic                 held_reg;
    logic                 held_next;

    logic                 accept;
    logic [ROW_WIDTH-1:0] row_in;
    logic [ROW_WIDTH-1:0] mask;
    logic [ROW_WIDTH-1:0] upper_row;
    logic [ROW_WIDTH-1:0] lower_up;
    logic [ROW_WIDTH-1:0] lower_row;
    out_item_t            upper_item;
    out_item_t            lower_item;
    out_item_t            head;
    push_t                push;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign row_in = s_axis_tdata[ROW_WIDTH-1:0];

    for (genvar i = 0; i < ROW_WIDTH; i++)
    begin : g_mask
        assign mask[i] = (cols_reg > COLS_W'(i));
    end

    // new state of the held middle row
    lgs_row #(.ROW_WIDTH(ROW_WIDTH)) u_row_upper (
        .up     (above_reg),
        .mid    (middle_reg),
        .dn     (row_in),
        .mask   (mask),
        .result (upper_row)
    );

    // bottom row of the grid, with nothing below
    assign lower_up = held_reg ? middle_reg : '0;

    lgs_row #(.ROW_WIDTH(ROW_WIDTH)) u_row_lower (
        .up     (lower_up),
        .mid    (row_in),
        .dn     ('0),
        .mask   (mask),
        .result (lower_row)
    );

    always_comb
    begin
        upper_item.row  = DATA_W'(upper_row);
        upper_item.last = 1'b0;
        lower_item.row  = DATA_W'(lower_row);
        lower_item.last = 1'b1;

        push.en0   = accept && (held_reg || s_axis_tlast);
        push.en1   = accept && held_reg && s_axis_tlast;
        push.item0 = held_reg ? upper_item : lower_item;
        push.item1 = lower_item;

        above_next  = above_reg;
        middle_next = middle_reg;
        held_next   = held_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                above_next  = '0;
                middle_next = '0;
                held_next   = 1'b0;
            end
            else
            begin
                above_next  = held_reg ? middle_reg : '0;
                middle_next = row_in;
                held_next   = 1'b1;
            end
        end
    end

    lgs_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop_ready  (m_axis_tready),
        .head       (head),
        .head_valid (m_axis_tvalid),
        .room       (s_axis_tready)
    );

    assign m_axis_tdata = head.row;
    assign m_axis_tlast = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= COLS_RESET;
            above_reg  <= '0;
            middle_reg <= '0;
            held_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cols_reg <= cfg_wdata;
            end
            above_reg  <= above_next;
            middle_reg <= middle_next;
            held_reg   <= held_next;
        end
    end

    `ASSERT_CLK(a_result_follows,
        accept && (held_reg || s_axis_tlast) |=> m_axis_tvalid,
        "result missing after accepted row")
    `ASSERT_CLK(a_last_clears,
        accept && s_axis_tlast |=> !held_reg && (middle_reg == '0) && (above_reg == '0),
        "state not cleared after last row")
    `ASSERT_NEVER(a_empty_ready, !m_axis_tvalid && !s_axis_tready,
        "input stalled with empty output queue")
    `ASSERT_CLK(a_no_above_alone, !held_reg |-> (above_reg == '0),
        "above row held without middle row")

endmodule

### rtl/lgs_cell.sv
module lgs_cell (
    input  logic [2:0] up,
    input  logic [2:0] mid,
    input  logic [2:0] dn,
    output logic       alive
);
    import lgs_pkg::*;

    logic [CNT_W-1:0] n;

    assign n = CNT_W'(up[0]) + CNT_W'(up[1]) + CNT_W'(up[2])
             + CNT_W'(mid[0]) + CNT_W'(mid[2])
             + CNT_W'(dn[0]) + CNT_W'(dn[1]) + CNT_W'(dn[2]);

    assign alive = (n == BORN_COUNT) || ((n == KEEP_COUNT) && mid[1]);

endmodule

### rtl/lgs_row.sv
module lgs_row #(
    parameter int ROW_WIDTH = 64
) (
    input  logic [ROW_WIDTH-1:0] up,
    input  logic [ROW_WIDTH-1:0] mid,
    input  logic [ROW_WIDTH-1:0] dn,
    input  logic [ROW_WIDTH-1:0] mask,
    output logic [ROW_WIDTH-1:0] result
);
    import lgs_pkg::*;

    // dead border cell on each side, no wrap
    logic [ROW_WIDTH+1:0] up_pad;
    logic [ROW_WIDTH+1:0] mid_pad;
    logic [ROW_WIDTH+1:0] dn_pad;
    logic [ROW_WIDTH-1:0] lane_out;

    assign up_pad  = {1'b0, up & mask, 1'b0};
    assign mid_pad = {1'b0, mid & mask, 1'b0};
    assign dn_pad  = {1'b0, dn & mask, 1'b0};

    for (genvar i = 0; i < ROW_WIDTH; i++) begin : g_lane
        lgs_cell u_cell (
            .up    (up_pad[i+2:i]),
            .mid   (mid_pad[i+2:i]),
            .dn    (dn_pad[i+2:i]),
            .alive (lane_out[i])
        );
    end

    assign result = lane_out & mask;

endmodule

### rtl/lgs_out_fifo.sv
module lgs_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  lgs_pkg::push_t      push,
    input  logic                pop_ready,
    output lgs_pkg::out_item_t  head,
    output logic                head_valid,
    output logic                room
);
    import lgs_pkg::*;

    out_item_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;
    logic               pop;

    assign head_valid   = (fill_reg != '0);
    assign head         = mem[rd_ptr_reg];
    assign pop          = head_valid && pop_ready;
    assign room         = (fill_reg <= FILL_W'(FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.en0) + PTR_W'(push.en1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        fill_next   = fill_reg + FILL_W'(push.en0) + FILL_W'(push.en1) - FILL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.en0)
        begin
            mem[wr_ptr_reg] <= push.item0;
        end
        if (push.en1)
        begin
            mem[wr_ptr_plus1] <= push.item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
